>>> rtl/control_surface_servo_mixer_top_defines.svh
// Assertion macros used by the servo mixer top level.
`ifndef CONTROL_SURFACE_SERVO_MIXER_TOP_DEFINES_SVH
`define CONTROL_SURFACE_SERVO_MIXER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define CSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define CSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSM_ASSERT(lbl, prop, msg)
`define CSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/csm_pkg.sv
// Types, constants and the clamp function of the servo mixer.
package csm_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned MotorW = 9;
  localparam int unsigned MixW   = 11;

  localparam logic [DataW-1:0] ElevMaxRst = 16'd200;
  localparam logic [DataW-1:0] ElevMinRst = 16'd100;
  localparam logic [DataW-1:0] AilMaxRst  = 16'd200;
  localparam logic [DataW-1:0] AilMinRst  = 16'd100;

  localparam logic signed [MixW-1:0] MixBaseHi = 11'sd200;
  localparam logic signed [MixW-1:0] MixBaseLo = 11'sd100;
  localparam logic [LevelW-1:0]      RollBias  = 8'd25;
  localparam logic [LevelW-1:0]      YawBias   = 8'd25;
  localparam logic [MotorW-1:0]      MotorBias = 9'd100;

  typedef enum logic [2:0] {
    FUNC_PITCH     = 3'd0,
    FUNC_ROLL      = 3'd1,
    FUNC_YAW       = 3'd2,
    FUNC_THROTTLE  = 3'd3,
    FUNC_FLAPS     = 3'd4,
    FUNC_TRIM_AIL  = 3'd5,
    FUNC_TRIM_ELEV = 3'd6,
    FUNC_MODE      = 3'd7
  } csm_func_t;

  typedef enum logic [1:0] {
    REG_ELEV_MAX = 2'd0,
    REG_ELEV_MIN = 2'd1,
    REG_AIL_MAX  = 2'd2,
    REG_AIL_MIN  = 2'd3
  } csm_reg_t;

  typedef struct packed {
    logic [DataW-1:0] elev_max;
    logic [DataW-1:0] elev_min;
    logic [DataW-1:0] ail_max;
    logic [DataW-1:0] ail_min;
  } csm_limits_t;

  typedef struct packed {
    logic [LevelW-1:0] pitch;
    logic [LevelW-1:0] roll;
    logic [LevelW-1:0] yaw;
    logic [LevelW-1:0] flap;
  } csm_levels_t;

  typedef struct packed {
    logic [DataW-1:0] elev_left;
    logic [DataW-1:0] elev_right;
    logic [DataW-1:0] ail_left;
    logic [DataW-1:0] ail_right;
  } csm_servo_t;

  // Upper limit is tested first, so a minimum above the maximum still
  // gives the maximum for large sums.
  function automatic logic [DataW-1:0] clamp_mix(input logic signed [MixW-1:0] sum,
                                                 input logic [DataW-1:0] hi,
                                                 input logic [DataW-1:0] lo);
    logic signed [DataW:0] sum_x;
    logic [DataW-1:0]      res;
    sum_x = (DataW+1)'(sum);
    if (sum_x > $signed({1'b0, hi})) begin
      res = hi;
    end else if (sum_x < $signed({1'b0, lo})) begin
      res = lo;
    end else begin
      res = sum_x[DataW-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/csm_mixer.sv
// Signed mix of the channel levels into four clamped servo compares.
module csm_mixer
  import csm_pkg::*;
(
  input  csm_levels_t levels,
  input  csm_limits_t limits,
  output csm_servo_t  servo
);

  logic signed [MixW-1:0] pitch_s;
  logic signed [MixW-1:0] roll_s;
  logic signed [MixW-1:0] yaw_s;
  logic signed [MixW-1:0] flap_s;
  logic signed [MixW-1:0] sum_el;
  logic signed [MixW-1:0] sum_er;
  logic signed [MixW-1:0] sum_al;
  logic signed [MixW-1:0] sum_ar;

  // Yaw is kept as a signed byte; the other levels are unsigned.
  assign pitch_s = $signed({{(MixW-LevelW){1'b0}}, levels.pitch});
  assign roll_s  = $signed({{(MixW-LevelW){1'b0}}, levels.roll});
  assign flap_s  = $signed({{(MixW-LevelW){1'b0}}, levels.flap});
  assign yaw_s   = $signed({{(MixW-LevelW){levels.yaw[LevelW-1]}}, levels.yaw});

  assign sum_el = MixBaseHi - pitch_s + yaw_s;
  assign sum_er = MixBaseLo + pitch_s + yaw_s;
  assign sum_al = MixBaseHi - roll_s + flap_s;
  assign sum_ar = MixBaseHi - roll_s - flap_s;

  assign servo.elev_left  = clamp_mix(sum_el, limits.elev_max, limits.elev_min);
  assign servo.elev_right = clamp_mix(sum_er, limits.elev_max, limits.elev_min);
  assign servo.ail_left   = clamp_mix(sum_al, limits.ail_max, limits.ail_min);
  assign servo.ail_right  = clamp_mix(sum_ar, limits.ail_max, limits.ail_min);

endmodule

>>> rtl/control_surface_servo_mixer_top.sv
// V-tail and flaperon servo mixer: command decode, channel state, result buffering.
//
// Usage: each transfer on the in_ channel carries one command (in_tuser
// selects the function, in_tdata holds the argument byte). Pitch, roll, yaw
// and flap commands update the stored channel levels; these and the two trim
// commands then produce one result holding four clamped servo compares
// (out_tuser[0] set). Throttle produces one result with only the motor
// compare (out_tuser[1] set). Mode commands produce nothing.
// The clamp limits are written on the cfg_ channel, which is always ready;
// write them only while no command is in flight.
// Decode and mix sit between the input transfer and the first result register,
// followed by the output register that drives out_. Throughput is one command
// per cycle while the receiver keeps taking results from out_ without stalling.
// When the receiver stalls, the output register holds its result and one
// more result is held in the first register; in_tready drops once both are
// full. Reset clears the channel levels, loads the default limits
// (elevator and aileron 100..200) and empties both result registers.
`include "control_surface_servo_mixer_top_defines.svh"

module control_surface_servo_mixer_top
  import csm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Command input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [2:0]  in_tuser,   // [2:0] func
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [15:0] elevator_left, [31:16] elevator_right,
                                  // [47:32] aileron_left, [63:48] aileron_right,
                                  // [72:64] motor_compare, [79:73] zero
  output logic [1:0]  out_tuser,  // [0] servo_valid, [1] motor_valid
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic              motor_valid;
    logic              servo_valid;
    logic [MotorW-1:0] motor;
    csm_servo_t        servo;
  } csm_result_t;

  csm_limits_t limits_r;
  csm_limits_t limits_nxt;
  csm_levels_t levels_r;
  csm_levels_t levels_nxt;
  csm_servo_t  mix;
  csm_result_t res_new;
  csm_result_t s1_res_r;
  csm_result_t out_res_r;
  csm_func_t   func;
  logic        in_fire;
  logic        has_result;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_load;

  assign func      = csm_func_t'(in_tuser);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid && cfg_ready) begin
      case (csm_reg_t'(cfg_index))
        REG_ELEV_MAX: limits_nxt.elev_max = cfg_data;
        REG_ELEV_MIN: limits_nxt.elev_min = cfg_data;
        REG_AIL_MAX:  limits_nxt.ail_max  = cfg_data;
        REG_AIL_MIN:  limits_nxt.ail_min  = cfg_data;
        default:      limits_nxt = limits_r;
      endcase
    end
  end

  // Command decode: the mix sees the levels as updated by this command.
  always_comb begin
    levels_nxt = levels_r;
    has_result = 1'b1;
    case (func)
      FUNC_PITCH: levels_nxt.pitch = in_tdata;
      FUNC_ROLL:  levels_nxt.roll  = {1'b0, in_tdata[LevelW-1:1]} + RollBias;
      FUNC_YAW:   levels_nxt.yaw   = in_tdata - YawBias;
      FUNC_FLAPS: levels_nxt.flap  = in_tdata;
      FUNC_MODE:  has_result = 1'b0;
      default:    levels_nxt = levels_r;
    endcase
  end

  csm_mixer u_mixer (
    .levels (levels_nxt),
    .limits (limits_r),
    .servo  (mix)
  );

  always_comb begin
    res_new = '0;
    if (func == FUNC_THROTTLE) begin
      res_new.motor_valid = 1'b1;
      res_new.motor       = {1'b0, in_tdata} + MotorBias;
    end else begin
      res_new.servo_valid = 1'b1;
      res_new.servo       = mix;
    end
  end

  // Two result registers: the first can take one more result while the output stalls.
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
    s1_valid_nxt  = s1_valid_r && !out_load;
    if (in_fire && has_result) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r    <= '{elev_max: ElevMaxRst, elev_min: ElevMinRst,
                       ail_max: AilMaxRst, ail_min: AilMinRst};
      levels_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limits_r    <= limits_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        levels_r <= levels_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      s1_res_r <= res_new;
    end
    if (out_load) begin
      out_res_r <= s1_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.motor_valid, out_res_r.servo_valid};
  assign out_tdata  = {7'd0, out_res_r.motor,
                       out_res_r.servo.ail_right, out_res_r.servo.ail_left,
                       out_res_r.servo.elev_right, out_res_r.servo.elev_left};

  `CSM_ASSERT(a_one_kind, out_tvalid |-> $onehot(out_tuser), "result must be servo or motor")
  `CSM_ASSERT(a_servo_no_motor, (out_tvalid && out_tuser[0]) |-> (out_tdata[72:64] == '0), "servo result carries a motor compare")
  `CSM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && !s1_valid_r), "result registers not empty after reset")
  `CSM_ASSERT(a_mode_silent, (in_fire && func == FUNC_MODE && !s1_valid_r) |=> !s1_valid_r, "mode command produced a result")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the control surface servo mixer: directed, limit and random traffic.
`timescale 1ns / 100ps

module testbench;
  import csm_pkg::*;

  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 500000;

  localparam int RollOffset   = 25;
  localparam int YawOffset    = 25;
  localparam int MotorOffset  = 100;
  localparam int ElevLeftBase = 200;
  localparam int ElevRightBase = 100;
  localparam int AilBase      = 200;

  typedef struct packed {
    logic              servo_valid;
    logic [DataW-1:0]  elev_left;
    logic [DataW-1:0]  elev_right;
    logic [DataW-1:0]  ail_left;
    logic [DataW-1:0]  ail_right;
    logic              motor_valid;
    logic [MotorW-1:0] motor_compare;
  } mix_result_t;

  typedef struct packed {
    csm_func_t  func;
    logic [7:0] value;
  } command_t;

  typedef enum {
    RX_ALWAYS,
    RX_RANDOM,
    RX_HEAVY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Mirror of the block's channel levels and clamp limits.
  logic [7:0]        pitch_lvl;
  logic [7:0]        roll_lvl;
  logic signed [7:0] yaw_lvl;
  logic [7:0]        flap_lvl;
  logic [DataW-1:0]  elev_hi;
  logic [DataW-1:0]  elev_lo;
  logic [DataW-1:0]  ail_hi;
  logic [DataW-1:0]  ail_lo;

  mix_result_t pending_results[$];
  mix_result_t want_r;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          tx_gaps = 1'b0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_hold = 0;

  control_surface_servo_mixer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [DataW-1:0] limit_mix(int sum, logic [DataW-1:0] hi,
                                                 logic [DataW-1:0] lo);
    int hi_i;
    int lo_i;
    hi_i = hi;
    lo_i = lo;
    // The upper bound wins for sums above it when the limits are inverted.
    if (sum > hi_i) return hi;
    if (sum < lo_i) return lo;
    return DataW'(sum);
  endfunction

  task automatic mix_command(csm_func_t func, logic [7:0] value);
    mix_result_t r;
    int pitch;
    int roll;
    int yaw;
    int flap;
    r = '0;
    case (func)
      FUNC_PITCH: pitch_lvl = value;
      FUNC_ROLL:  roll_lvl = 8'(value / 2 + RollOffset);
      FUNC_YAW:   yaw_lvl = 8'(value - YawOffset);
      FUNC_FLAPS: flap_lvl = value;
      FUNC_THROTTLE: begin
        r.motor_valid = 1'b1;
        r.motor_compare = MotorW'(value) + MotorW'(MotorOffset);
        pending_results.push_back(r);
        return;
      end
      FUNC_MODE: return;
      default: ;
    endcase
    pitch = pitch_lvl;
    roll = roll_lvl;
    yaw = yaw_lvl;
    flap = flap_lvl;
    r.servo_valid = 1'b1;
    r.elev_left = limit_mix(ElevLeftBase - pitch + yaw, elev_hi, elev_lo);
    r.elev_right = limit_mix(ElevRightBase + pitch + yaw, elev_hi, elev_lo);
    r.ail_left = limit_mix(AilBase - roll + flap, ail_hi, ail_lo);
    r.ail_right = limit_mix(AilBase - roll - flap, ail_hi, ail_lo);
    pending_results.push_back(r);
  endtask

  task automatic compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Prediction, register mirror and result checking share one process so that
  // their relative order is fixed.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      mix_command(csm_func_t'(in_tuser), in_tdata);
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (csm_reg_t'(cfg_index))
        REG_ELEV_MAX: elev_hi = cfg_data;
        REG_ELEV_MIN: elev_lo = cfg_data;
        REG_AIL_MAX:  ail_hi = cfg_data;
        REG_AIL_MIN:  ail_lo = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: tuser=%b tdata=%h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        want_r = pending_results.pop_front();
        compare_field("servo_valid", DataW'(want_r.servo_valid), DataW'(out_tuser[0]));
        compare_field("motor_valid", DataW'(want_r.motor_valid), DataW'(out_tuser[1]));
        compare_field("elevator_left", want_r.elev_left, out_tdata[15:0]);
        compare_field("elevator_right", want_r.elev_right, out_tdata[31:16]);
        compare_field("aileron_left", want_r.ail_left, out_tdata[47:32]);
        compare_field("aileron_right", want_r.ail_right, out_tdata[63:48]);
        compare_field("motor_compare", DataW'(want_r.motor_compare),
                      DataW'(out_tdata[72:64]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: out_tready stays high in RX_ALWAYS, else toggles after a randomly held period.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: begin
          out_tready <= !out_tready;
          rx_hold <= out_tready ? idle_len() : $urandom_range(0, 15);
        end
        default: begin
          out_tready <= !out_tready;
          rx_hold <= out_tready ? $urandom_range(10, 60) : $urandom_range(0, 2);
        end
      endcase
    end
  end

  task automatic send_command(csm_func_t func, logic [7:0] value);
    int gap;
    gap = tx_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_list(command_t cmds[]);
    foreach (cmds[i]) send_command(cmds[i].func, cmds[i].value);
  endtask

  task automatic random_commands(int count);
    int r;
    logic [7:0] value;
    repeat (count) begin
      r = $urandom_range(0, 9);
      value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      send_command(csm_func_t'($urandom_range(0, 7)), value);
    end
  endtask

  // A mode command leaves no result behind, so a drain wait follows the
  // last result before the block counts as idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] e_hi, logic [15:0] e_lo,
                            logic [15:0] a_hi, logic [15:0] a_lo);
    csm_reg_t   regs[4];
    logic [15:0] vals[4];
    regs = '{REG_ELEV_MAX, REG_ELEV_MIN, REG_AIL_MAX, REG_AIL_MIN};
    vals = '{e_hi, e_lo, a_hi, a_lo};
    wait_idle();
    cfg_valid <= 1'b1;
    foreach (regs[i]) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    command_t cmds[];
    cmds = '{
      '{FUNC_TRIM_AIL, 8'h00}, '{FUNC_PITCH, 8'hFF}, '{FUNC_PITCH, 8'h00},
      '{FUNC_ROLL, 8'h00}, '{FUNC_ROLL, 8'hFF}, '{FUNC_YAW, 8'h00},
      '{FUNC_YAW, 8'hFF}, '{FUNC_YAW, 8'd152}, '{FUNC_YAW, 8'd153},
      '{FUNC_YAW, 8'd25}, '{FUNC_FLAPS, 8'hFF}, '{FUNC_FLAPS, 8'h00},
      '{FUNC_THROTTLE, 8'h00}, '{FUNC_THROTTLE, 8'hFF}, '{FUNC_TRIM_ELEV, 8'hAA},
      '{FUNC_MODE, 8'h00}, '{FUNC_MODE, 8'hFF}, '{FUNC_PITCH, 8'h55},
      '{FUNC_PITCH, 8'hAA}, '{FUNC_ROLL, 8'h55}, '{FUNC_FLAPS, 8'hAA},
      '{FUNC_TRIM_ELEV, 8'h55}, '{FUNC_THROTTLE, 8'h80}
    };
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    send_list(cmds);
  endtask

  // Full-range limits: a negative mix must clamp to zero rather than wrap.
  task automatic test_wide_limits();
    command_t cmds[];
    cmds = '{
      '{FUNC_PITCH, 8'hFF}, '{FUNC_YAW, 8'h00}, '{FUNC_ROLL, 8'hFF},
      '{FUNC_FLAPS, 8'hFF}, '{FUNC_YAW, 8'd152}, '{FUNC_PITCH, 8'h00},
      '{FUNC_TRIM_AIL, 8'h00}
    };
    set_limits(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    send_list(cmds);
    random_commands(170);
  endtask

  // Minimum above maximum on both clamps.
  task automatic test_inverted_limits();
    set_limits(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    random_commands(110);
  endtask

  task automatic test_random_limits();
    logic [15:0] lim[4];
    int r;
    for (int round = 0; round < 4; round++) begin
      for (int k = 0; k < 4; k += 2) begin
        r = $urandom_range(0, 7);
        if (r == 0) begin
          lim[k] = 16'($urandom);
          lim[k + 1] = 16'($urandom);
        end else begin
          lim[k + 1] = 16'($urandom_range(0, 250));
          lim[k] = 16'($urandom_range(lim[k + 1], 450));
          if (r == 1) {lim[k], lim[k + 1]} = {lim[k + 1], lim[k]};
        end
      end
      set_limits(lim[0], lim[1], lim[2], lim[3]);
      tx_gaps = round[0];
      rx_mode = round[1] ? RX_RANDOM : RX_ALWAYS;
      random_commands(100);
    end
  endtask

  // Back-to-back traffic, then a receiver that stalls long enough to fill
  // the result buffer and push back on the input.
  task automatic test_back_pressure();
    set_limits(16'd200, 16'd100, 16'd200, 16'd100);
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    random_commands(120);
    rx_mode = RX_HEAVY;
    random_commands(120);
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pitch_lvl = '0;
    roll_lvl = '0;
    yaw_lvl = '0;
    flap_lvl = '0;
    elev_hi = 16'd200;
    elev_lo = 16'd100;
    ail_hi = 16'd200;
    ail_lo = 16'd100;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_wide_limits();
    test_inverted_limits();
    test_random_limits();
    test_back_pressure();

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
